### rtl/core/lfu_pkg.sv
package lfu_pkg;

	localparam int PAGE_W  = 20;
	localparam int CNT_W   = 32;
	localparam int LIMIT_W = 10;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
	localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	// scan status handed from the victim scan to the sequencer
	typedef struct packed {
		logic found;
		logic have_min;
	} scan_flags_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

### rtl/core/lfu_if.sv
interface lfu_access_if;
	logic          valid;
	logic          ready;
	lfu_pkg::page_t page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

interface lfu_result_if;
	logic           valid;
	logic           ready;
	logic           hit;
	logic           evicted_valid;
	lfu_pkg::page_t evicted_page;
	lfu_pkg::cnt_t  hit_total;
	lfu_pkg::cnt_t  miss_total;
	logic           order_overflow;

	modport source (output valid, output hit, output evicted_valid, output evicted_page,
		output hit_total, output miss_total, output order_overflow, input ready);
	modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
		input hit_total, input miss_total, input order_overflow, output ready);
endinterface

### rtl/core/lfu_page_replacement.sv
// LFU page store: an access is accepted, then the resident frames are read one by one
// from the frame RAM through its single read port, then the entry is written back.
// A new access is accepted only once the previous one has been written back.
// Reset (arst_n low) clears frame count, access number, hit/miss totals and sets the
// frame limit to 64; frame RAM contents stay undefined, frames below the count are valid.
module lfu_page_replacement #(
	parameter int FRAMES    = 512,
	parameter int PAGE_BITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::LIMIT_W-1:0] cfg_wdata,
	lfu_access_if.sink                  access,
	lfu_result_if.source                result
);
	import lfu_pkg::*;

	// stored page width: the port carries at most PAGE_W bits
	localparam int SW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	logic [1:0]    state_q;
	limit_t        limit_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] addr_q;
	cnt_t          access_q;
	cnt_t          hits_q;
	cnt_t          misses_q;
	logic [SW-1:0] key_q;

	logic          rd_en;
	logic          rd_v_s1;
	logic [IW-1:0] ridx_s1;
	logic [SW-1:0] rpage;
	cnt_t          ruses;
	cnt_t          rorder;

	scan_flags_t   flags;
	logic [IW-1:0] found_idx;
	cnt_t          found_uses;
	logic [IW-1:0] min_idx;
	logic [SW-1:0] min_page;

	logic [31:0]   eff_limit;
	logic          has_room;
	logic          wb_fire;
	logic          we;
	logic [IW-1:0] waddr;
	cnt_t          wuses;

	logic          res_valid_q;
	logic          res_hit_q;
	logic          res_ev_q;
	page_t         res_page_q;
	cnt_t          res_hits_q;
	cnt_t          res_misses_q;
	logic          res_ovf_q;

	// Limit of zero acts as one, anything past the frame count saturates.
	always_comb begin
		if (limit_q == '0) eff_limit = 32'd1;
		else if (32'(limit_q) > 32'(FRAMES)) eff_limit = 32'(FRAMES);
		else eff_limit = 32'(limit_q);
	end

	// Frames fill from the bottom and never free, so valid means index below the count.
	assign has_room = 32'(used_q) < eff_limit;
	assign rd_en    = (state_q == ST_SCAN) && (addr_q < used_q);
	assign wb_fire  = (state_q == ST_WB) && (!res_valid_q || result.ready);
	assign access.ready = (state_q == ST_IDLE);

	// Write-back target: bump the hit entry, take a free frame, or overwrite the victim.
	always_comb begin
		we    = wb_fire;
		waddr = min_idx;
		wuses = CNT_W'(1);
		if (flags.found) begin
			waddr = found_idx;
			wuses = sat_inc(found_uses);
		end else if (has_room) begin
			waddr = used_q[IW-1:0];
		end
	end

	lfu_frame_ram #(.DEPTH(FRAMES), .PW(SW), .IW(IW)) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wpage  (key_q),
		.wuses  (wuses),
		.worder (access_q),
		.re     (rd_en),
		.raddr  (addr_q[IW-1:0]),
		.rpage  (rpage),
		.ruses  (ruses),
		.rorder (rorder)
	);

	lfu_victim_scan #(.PW(SW), .IW(IW)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (access.valid && access.ready),
		.smp        (rd_v_s1),
		.idx        (ridx_s1),
		.key        (key_q),
		.epage      (rpage),
		.euses      (ruses),
		.eorder     (rorder),
		.flags      (flags),
		.found_idx  (found_idx),
		.found_uses (found_uses),
		.min_idx    (min_idx),
		.min_page   (min_page)
	);

	// Sequencer: accept, sweep the resident frames, write back once the result slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			limit_q  <= LIMIT_RESET;
			used_q   <= '0;
			addr_q   <= '0;
			access_q <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			rd_v_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (access.valid) begin
						addr_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// the last read lands in the scan registers on this edge
					if (rd_en) addr_q <= addr_q + CW'(1);
					else state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_fire) begin
						access_q <= sat_inc(access_q);
						if (flags.found) begin
							hits_q <= sat_inc(hits_q);
						end else begin
							misses_q <= sat_inc(misses_q);
							if (has_room) used_q <= used_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) ridx_s1 <= addr_q[IW-1:0];
		if (access.valid && access.ready) key_q <= access.page[SW-1:0];
	end

	// Result register: hold the transaction until taken, load on write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (wb_fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			res_hit_q    <= flags.found;
			res_ev_q     <= !flags.found && !has_room;
			res_page_q   <= (!flags.found && !has_room) ? PAGE_W'(min_page) : '0;
			res_hits_q   <= flags.found ? sat_inc(hits_q) : hits_q;
			res_misses_q <= flags.found ? misses_q : sat_inc(misses_q);
			res_ovf_q    <= (sat_inc(access_q) == CNT_MAX);
		end
	end

	assign result.valid          = res_valid_q;
	assign result.hit            = res_hit_q;
	assign result.evicted_valid  = res_ev_q;
	assign result.evicted_page   = res_page_q;
	assign result.hit_total      = res_hits_q;
	assign result.miss_total     = res_misses_q;
	assign result.order_overflow = res_ovf_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(FRAMES))
		else $error("frame count past frame store depth");

	a_write_only_wb: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_WB))
		else $error("frame RAM written outside write-back");

	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= used_q))
		else $error("scan address past resident frames");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_fire && !flags.found && !has_room) |-> flags.have_min)
		else $error("eviction without a victim");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.hit && result.evicted_valid))
		else $error("hit reported with an eviction");

endmodule

### rtl/core/lfu_frame_ram.sv
module lfu_frame_ram #(
	parameter int DEPTH = 512,
	parameter int PW    = 20,
	parameter int IW    = 9
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [IW-1:0]          waddr,
	input  logic [PW-1:0]          wpage,
	input  logic [lfu_pkg::CNT_W-1:0] wuses,
	input  logic [lfu_pkg::CNT_W-1:0] worder,
	input  logic                   re,
	input  logic [IW-1:0]          raddr,
	output logic [PW-1:0]          rpage,
	output logic [lfu_pkg::CNT_W-1:0] ruses,
	output logic [lfu_pkg::CNT_W-1:0] rorder
);
	import lfu_pkg::*;

	logic [PW-1:0] page_mem  [DEPTH];
	cnt_t          uses_mem  [DEPTH];
	cnt_t          order_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			page_mem[waddr]  <= wpage;
			uses_mem[waddr]  <= wuses;
			order_mem[waddr] <= worder;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rpage  <= page_mem[raddr];
			ruses  <= uses_mem[raddr];
			rorder <= order_mem[raddr];
		end
	end

endmodule

### rtl/core/lfu_victim_scan.sv
module lfu_victim_scan #(
	parameter int PW = 20,
	parameter int IW = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic                      smp,
	input  logic [IW-1:0]             idx,
	input  logic [PW-1:0]             key,
	input  logic [PW-1:0]             epage,
	input  logic [lfu_pkg::CNT_W-1:0] euses,
	input  logic [lfu_pkg::CNT_W-1:0] eorder,
	output lfu_pkg::scan_flags_t      flags,
	output logic [IW-1:0]             found_idx,
	output logic [lfu_pkg::CNT_W-1:0] found_uses,
	output logic [IW-1:0]             min_idx,
	output logic [PW-1:0]             min_page
);
	import lfu_pkg::*;

	logic    found_q;
	logic    have_min_q;
	cnt_t    min_uses_q;
	cnt_t    min_order_q;
	logic    take_min;

	// strict compare keeps the lowest index among full ties
	assign take_min = !have_min_q || (euses < min_uses_q) ||
		((euses == min_uses_q) && (eorder < min_order_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			have_min_q <= 1'b0;
		end else if (clr) begin
			found_q    <= 1'b0;
			have_min_q <= 1'b0;
		end else if (smp) begin
			if (!found_q && (epage == key)) found_q <= 1'b1;
			if (take_min) have_min_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (smp && !clr) begin
			if (!found_q && (epage == key)) begin
				found_idx  <= idx;
				found_uses <= euses;
			end
			if (take_min) begin
				min_idx     <= idx;
				min_uses_q  <= euses;
				min_order_q <= eorder;
				min_page    <= epage;
			end
		end
	end

	assign flags.found    = found_q;
	assign flags.have_min = have_min_q;

endmodule
